### rtl/assert_macros.svh
// assertion helpers for the rtl files
// all checks sample on clk_i; CALU_ASSERT checks are off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CALU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property that must also hold while reset is applied
`define CALU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/calu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

  // operation codes carried in tuser
  typedef enum logic [4:0] {
    MODE_ADD = 5'd0,
    MODE_ADC = 5'd1,
    MODE_SUB = 5'd2,
    MODE_SBB = 5'd3,
    MODE_ANA = 5'd4,
    MODE_XRA = 5'd5,
    MODE_ORA = 5'd6,
    MODE_CMP = 5'd7,
    MODE_INR = 5'd8,
    MODE_DCR = 5'd9,
    MODE_RLC = 5'd10,
    MODE_RRC = 5'd11,
    MODE_RAL = 5'd12,
    MODE_RAR = 5'd13,
    MODE_DAA = 5'd14,
    MODE_CMA = 5'd15,
    MODE_STC = 5'd16,
    MODE_CMC = 5'd17
  } mode_e;

  // flag byte bit positions
  localparam int unsigned FlagS  = 7;
  localparam int unsigned FlagZ  = 6;
  localparam int unsigned FlagAc = 4;
  localparam int unsigned FlagP  = 2;
  localparam int unsigned FlagC  = 0;

  // decimal adjust constants
  localparam logic [3:0] BcdMax     = 4'h9;
  localparam logic [8:0] DaaLowAdd  = 9'h006;
  localparam logic [8:0] DaaHighAdd = 9'h060;
  localparam logic [3:0] NibbleMax  = 4'hf;

  // one operation as it enters the datapath
  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [7:0] flags;
  } calu_item_t;

  // one finished operation
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags;
  } calu_res_t;

  // sign, zero and even parity from a result byte
  function automatic logic [7:0] szp(input logic [7:0] f, input logic [7:0] r);
    logic [7:0] o;
    o         = f;
    o[FlagS]  = r[7];
    o[FlagZ]  = (r == 8'h00);
    o[FlagP]  = ~^r;
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/calu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module calu_exec import calu_pkg::*; (
  input  calu_item_t item_i,
  output calu_res_t  res_o
);

  logic [7:0] a;
  logic [7:0] v;
  logic [7:0] f;
  logic       cin;
  logic [8:0] sum9;
  logic [4:0] half5;
  logic [8:0] need9;
  logic [4:0] nib5;
  logic [7:0] diff;
  logic [7:0] inc_r;
  logic [7:0] dec_r;
  logic       lo_adj;
  logic       hi_adj;
  logic [8:0] daa1;
  logic [8:0] daa2;
  logic       daa_ac;
  logic [7:0] r;
  logic [7:0] fo;

  assign a = item_i.acc;
  assign v = item_i.opnd;
  assign f = item_i.flags;

  // carry in only for adc and sbb
  assign cin = f[FlagC] & ((item_i.mode == MODE_ADC) || (item_i.mode == MODE_SBB));

  // adder with half carry
  assign sum9  = {1'b0, a} + {1'b0, v} + {8'b0, cin};
  assign half5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cin};

  // subtractor with borrow and nibble no-borrow
  assign need9 = {1'b0, v} + {8'b0, cin};
  assign nib5  = {1'b0, v[3:0]} + {4'b0, cin};
  assign diff  = a - v - {7'b0, cin};

  // increment and decrement of the operand
  assign inc_r = v + 8'd1;
  assign dec_r = v - 8'd1;

  // decimal adjust in two correction steps
  assign lo_adj = (a[3:0] > BcdMax) || f[FlagAc];
  assign daa1   = {1'b0, a} + (lo_adj ? DaaLowAdd : 9'h000);
  assign daa_ac = lo_adj ? (a[3:0] > BcdMax) : f[FlagAc];
  assign hi_adj = (daa1[8:4] > {1'b0, BcdMax}) || f[FlagC];
  assign daa2   = daa1 + (hi_adj ? DaaHighAdd : 9'h000);

  // operation select
  always_comb begin
    r  = a;
    fo = f;
    unique case (item_i.mode) inside
      MODE_ADD, MODE_ADC: begin
        r          = sum9[7:0];
        fo[FlagAc] = half5[4];
        fo[FlagC]  = sum9[8];
        fo         = szp(fo, r);
      end
      MODE_SUB, MODE_SBB, MODE_CMP: begin
        fo[FlagC]  = (need9 > {1'b0, a});
        fo[FlagAc] = (nib5 <= {1'b0, a[3:0]});
        fo         = szp(fo, diff);
        if (item_i.mode != MODE_CMP) begin
          r = diff;
        end
      end
      MODE_ANA: begin
        r          = a & v;
        fo[FlagAc] = a[3] | v[3];
        fo[FlagC]  = 1'b0;
        fo         = szp(fo, r);
      end
      MODE_XRA, MODE_ORA: begin
        r          = (item_i.mode == MODE_XRA) ? (a ^ v) : (a | v);
        fo[FlagAc] = 1'b0;
        fo[FlagC]  = 1'b0;
        fo         = szp(fo, r);
      end
      MODE_INR: begin
        r          = inc_r;
        fo         = szp(fo, r);
        fo[FlagAc] = (inc_r[3:0] == 4'h0);
      end
      MODE_DCR: begin
        r          = dec_r;
        fo         = szp(fo, r);
        fo[FlagAc] = (dec_r[3:0] != NibbleMax);
      end
      MODE_RLC: begin
        r         = {a[6:0], a[7]};
        fo[FlagC] = a[7];
      end
      MODE_RRC: begin
        r         = {a[0], a[7:1]};
        fo[FlagC] = a[0];
      end
      MODE_RAL: begin
        r         = {a[6:0], f[FlagC]};
        fo[FlagC] = a[7];
      end
      MODE_RAR: begin
        r         = {f[FlagC], a[7:1]};
        fo[FlagC] = a[0];
      end
      MODE_DAA: begin
        r          = daa2[7:0];
        fo[FlagAc] = daa_ac;
        fo[FlagC]  = hi_adj;
        fo         = szp(fo, r);
      end
      MODE_CMA: begin
        r = ~a;
      end
      MODE_STC: begin
        fo[FlagC] = 1'b1;
      end
      MODE_CMC: begin
        fo[FlagC] = ~f[FlagC];
      end
      default: begin
        // undefined codes leave everything as it was
        r  = a;
        fo = f;
      end
    endcase
  end

  assign res_o.result = r;
  assign res_o.flags  = fo;

endmodule

`default_nettype wire

### rtl/cpu_alu_8bit_with_flags_core.sv
// pipeline: input register, single-pass alu, then result register
// throughput: one beat per cycle unless the output stalls, set by the single-pass alu
//   between the input register and the result register
// reset: asynchronous, active low; clears both stage valid bits, payload is not reset
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cpu_alu_8bit_with_flags_core import calu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // accumulator[7:0], operand[15:8], flags_in[23:16]
  input  logic [4:0]  s_axis_tuser_i,   // mode[4:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // result[7:0], flags_out[15:8]
);

  logic       in_vld_q;
  logic       in_vld_d;
  calu_item_t item_q;
  logic       out_vld_q;
  logic       out_vld_d;
  calu_res_t  res_q;
  calu_res_t  res;
  logic       out_rdy;
  logic       in_rdy;
  logic       in_beat;
  logic       in_stall;
  logic       cmp_op;
  logic       rot_op;

  // ready chain: each stage moves when the next one frees up
  assign out_rdy = !out_vld_q || m_axis_tready_i;
  assign in_rdy  = !in_vld_q || out_rdy;
  assign in_beat = s_axis_tvalid_i && in_rdy;

  assign s_axis_tready_o = in_rdy;

  // input stage
  assign in_vld_d = in_rdy ? s_axis_tvalid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q.mode  <= s_axis_tuser_i;
      item_q.acc   <= s_axis_tdata_i[7:0];
      item_q.opnd  <= s_axis_tdata_i[15:8];
      item_q.flags <= s_axis_tdata_i[23:16];
    end
  end

  // alu datapath
  calu_exec u_exec (
    .item_i (item_q),
    .res_o  (res)
  );

  // result stage
  assign out_vld_d = out_rdy ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && in_vld_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.flags, res_q.result};

  // conditions watched by the checks
  assign in_stall = in_vld_q && !out_rdy;
  assign cmp_op   = in_vld_q && (item_q.mode == MODE_CMP);
  assign rot_op   = in_vld_q && (item_q.mode inside {MODE_RLC, MODE_RRC, MODE_RAL, MODE_RAR});

  // checks
  `CALU_ASSERT(a_stage_advance, in_vld_q && out_rdy |=> out_vld_q, "stage 1 beat not moved")
  `CALU_ASSERT(a_stage_hold, in_stall |=> in_vld_q && $stable(item_q), "stalled beat changed")
  `CALU_ASSERT(a_cmp_keeps_acc, cmp_op |-> res.result == item_q.acc, "compare changed acc")
  `CALU_ASSERT(a_rot_flags, rot_op |-> res.flags[7:1] == item_q.flags[7:1], "rotate flags")

endmodule

`default_nettype wire
